@@ hdl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, codes and helpers of the RPN calculator stack engine.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int RPN_STACK_DEPTH = 16;
	localparam int VALUE_W         = 32;
	localparam int DEPTH_FIELD_W   = 5;

	// Divider geometry: a 48-bit dividend (top entry scaled by 2^16) over a
	// 32-bit divisor magnitude, two quotient bits retired per cycle.
	localparam int DIV_NUM_W      = 48;
	localparam int DIV_DEN_W      = 32;
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_CYCLES     = DIV_NUM_W / DIV_RADIX_BITS;

	localparam logic signed [63:0] Q_MAX_EXT = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN_EXT = -64'sd2147483648;

	typedef enum logic [2:0] {
		REQ_PUSH   = 3'd0,
		REQ_ADD    = 3'd1,
		REQ_SUB    = 3'd2,
		REQ_MUL    = 3'd3,
		REQ_DIV    = 3'd4,
		REQ_SQUARE = 3'd5,
		REQ_POP    = 3'd6,
		REQ_CLEAR  = 3'd7
	} rpn_req_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FEW   = 3'd1,
		ST_DIVZ  = 3'd2,
		ST_FULL  = 3'd3,
		ST_EMPTY = 3'd4,
		ST_SAT   = 3'd5
	} rpn_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_OPER,
		S_DIV,
		S_FINISH
	} rpn_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic rd_go;
		logic rd_latch;
		logic mul_go;
		logic div_go;
		logic commit;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_read;
		logic use_mul;
		logic use_div;
		logic div_zero;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               sat;
	} clamp_t;

	function automatic clamp_t clamp_q(input logic signed [63:0] v);
		clamp_t c;
		c.value = v[VALUE_W-1:0];
		c.sat   = 1'b0;
		if (v > Q_MAX_EXT) begin
			c.value = Q_MAX_EXT[VALUE_W-1:0];
			c.sat   = 1'b1;
		end else if (v < Q_MIN_EXT) begin
			c.value = Q_MIN_EXT[VALUE_W-1:0];
			c.sat   = 1'b1;
		end
		return c;
	endfunction

endpackage

@@ hdl/rpn_req_if.sv @@
// ----------------------------------------------------------------------------
// rpn_req_if
// Request channel: one word is one calculator request.
// ----------------------------------------------------------------------------
interface rpn_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic signed [31:0] push_value;

	modport source(output valid, output req_type, output push_value, input ready);
	modport sink(input valid, input req_type, input push_value, output ready);
endinterface

@@ hdl/rpn_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rpn_rsp_if
// Response channel: one word per request.
// ----------------------------------------------------------------------------
interface rpn_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic [4:0]         stack_depth;
	logic [2:0]         status;

	modport source(output valid, output result_value, output stack_depth, output status,
		input ready);
	modport sink(input valid, input result_value, input stack_depth, input status,
		output ready);
endinterface

@@ hdl/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/rpn_div.sv @@
// ----------------------------------------------------------------------------
// rpn_div
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic [DIV_NUM_W-1:0] quotient,
	output logic                 done
);

	localparam int CNT_W = $clog2(DIV_CYCLES);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] dvs_q;

	logic [DIV_DEN_W-1:0] rem_n;
	logic [DIV_NUM_W-1:0] quo_n;
	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   diff;
	logic                 qbit;

	// The dividend shifts out of the top of quo_q while quotient bits enter
	// at the bottom; after the last step quo_q holds the whole quotient.
	always_comb begin
		rem_n   = rem_q;
		quo_n   = quo_q;
		shifted = '0;
		diff    = '0;
		qbit    = 1'b0;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			shifted = {rem_n, quo_n[DIV_NUM_W-1]};
			diff    = shifted - {1'b0, dvs_q};
			qbit    = (shifted >= {1'b0, dvs_q});
			rem_n   = qbit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
			quo_n   = {quo_n[DIV_NUM_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_CYCLES - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient = quo_q;
	assign done     = ~busy_q;

endmodule

@@ hdl/rpn_dp.sv @@
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath: top-of-stack register, stack RAM below it, multiplier, divider
// and the response word register.
// ----------------------------------------------------------------------------
module rpn_dp import rpn_pkg::*; #(
	parameter int STACK_DEPTH = RPN_STACK_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] push_value,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	rpn_rsp_if.source          rsp
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// The top entry lives in top_q; entries below it sit in the RAM at their
	// stack position, so an operation needs only one RAM read.
	rpn_req_t                 req_q;
	logic signed [31:0]       pv_q;
	logic [CW-1:0]            count_q;
	logic signed [31:0]       top_q;
	logic signed [31:0]       opnd_q;
	logic signed [63:0]       prod_s1;
	logic                     div_neg_q;

	logic                     out_valid_q;
	logic [31:0]              res_value_q;
	logic [DEPTH_FIELD_W-1:0] res_depth_q;
	logic [2:0]               res_status_q;

	logic                     full;
	logic                     ge1;
	logic                     ge2;
	logic                     binary;
	logic [CW-1:0]            cnt_m1;
	logic [CW-1:0]            cnt_m2;
	logic [31:0]              ram_rdata;
	logic                     ram_we;

	logic signed [31:0]       mul_b;
	logic signed [63:0]       prod_w;
	logic signed [32:0]       t_ext;
	logic signed [32:0]       s_ext;
	logic signed [32:0]       sum_w;
	logic signed [32:0]       dif_w;
	logic [DIV_NUM_W-1:0]     num_raw;
	logic [DIV_NUM_W-1:0]     num_mag;
	logic [DIV_DEN_W-1:0]     den_mag;
	logic [DIV_NUM_W-1:0]     quo;
	logic [DIV_NUM_W:0]       q_ext;
	logic [DIV_NUM_W:0]       q_s;
	logic signed [63:0]       arith_w;
	clamp_t                   cl;
	logic                     div_done;

	logic [CW-1:0]            nxt_count;
	logic signed [31:0]       nxt_top;
	logic [31:0]              res_val;
	rpn_status_t              res_status;
	logic [31:0]              top_or_zero;
	logic [CW+DEPTH_FIELD_W-1:0] depth_ext;

	assign full   = (count_q == CW'(STACK_DEPTH));
	assign ge1    = (count_q != '0);
	assign ge2    = (count_q > CW'(1));
	assign binary = (req_q == REQ_ADD) || (req_q == REQ_SUB) ||
	                (req_q == REQ_MUL) || (req_q == REQ_DIV);
	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign top_or_zero = ge1 ? top_q : '0;

	assign stat.need_read = ge2 && (binary || (req_q == REQ_POP));
	assign stat.use_mul   = ((req_q == REQ_MUL) && ge2) || ((req_q == REQ_SQUARE) && ge1);
	assign stat.use_div   = (req_q == REQ_DIV) && ge2;
	assign stat.div_zero  = (opnd_q == '0);
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || rsp.ready;

	rpn_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (cnt_m1[AW-1:0]),
		.wdata  (top_q),
		.re     (cmd.rd_go),
		.raddr  (cnt_m2[AW-1:0]),
		.rdata_q(ram_rdata)
	);

	// Multiplier operands and divider operand magnitudes.
	assign mul_b   = (req_q == REQ_SQUARE) ? top_q : opnd_q;
	assign prod_w  = top_q * mul_b;
	assign num_raw = {top_q, 16'h0000};
	assign num_mag = top_q[31] ? (DIV_NUM_W'(0) - num_raw) : num_raw;
	assign den_mag = opnd_q[31] ? (DIV_DEN_W'(0) - opnd_q) : opnd_q;

	rpn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_go),
		.dividend(num_mag),
		.divisor (den_mag),
		.quotient(quo),
		.done    (div_done)
	);

	assign t_ext = {top_q[31], top_q};
	assign s_ext = {opnd_q[31], opnd_q};
	assign sum_w = t_ext + s_ext;
	assign dif_w = t_ext - s_ext;
	assign q_ext = {1'b0, quo};
	assign q_s   = div_neg_q ? ((DIV_NUM_W + 1)'(0) - q_ext) : q_ext;

	// Arithmetic shift right of the product rounds toward minus infinity.
	always_comb begin
		unique case (req_q)
			REQ_SUB:               arith_w = {{31{dif_w[32]}}, dif_w};
			REQ_MUL, REQ_SQUARE:   arith_w = prod_s1 >>> 16;
			REQ_DIV:               arith_w = {{(63 - DIV_NUM_W){q_s[DIV_NUM_W]}}, q_s};
			default:               arith_w = {{31{sum_w[32]}}, sum_w};
		endcase
	end

	assign cl = clamp_q(arith_w);

	// Outcome of the request, applied when the controller commits it.
	always_comb begin
		nxt_count  = count_q;
		nxt_top    = top_q;
		res_val    = top_or_zero;
		res_status = ST_OK;
		ram_we     = 1'b0;
		unique case (req_q)
			REQ_PUSH: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					ram_we    = cmd.commit && ge1;
					nxt_top   = pv_q;
					nxt_count = count_q + CW'(1);
					res_val   = pv_q;
				end
			end
			REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
				if (!ge2) begin
					res_status = ST_FEW;
				end else if ((req_q == REQ_DIV) && (opnd_q == '0)) begin
					res_status = ST_DIVZ;
				end else begin
					nxt_top    = cl.value;
					nxt_count  = cnt_m1;
					res_val    = cl.value;
					res_status = cl.sat ? ST_SAT : ST_OK;
				end
			end
			REQ_SQUARE: begin
				if (!ge1) begin
					res_status = ST_FEW;
				end else begin
					nxt_top    = cl.value;
					res_val    = cl.value;
					res_status = cl.sat ? ST_SAT : ST_OK;
				end
			end
			REQ_POP: begin
				if (!ge1) begin
					res_status = ST_EMPTY;
				end else begin
					// With a single entry opnd_q is stale, but the stack is
					// then empty and top_q is never read.
					nxt_top   = opnd_q;
					nxt_count = cnt_m1;
					res_val   = top_q;
				end
			end
			REQ_CLEAR: begin
				nxt_count = '0;
				res_val   = '0;
			end
		endcase
	end

	assign depth_ext = {{DEPTH_FIELD_W{1'b0}}, nxt_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= nxt_count;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= rpn_req_t'(req_type);
			pv_q  <= push_value;
		end
		if (cmd.rd_latch) begin
			opnd_q <= ram_rdata;
		end
		if (cmd.mul_go) begin
			prod_s1 <= prod_w;
		end
		if (cmd.div_go) begin
			div_neg_q <= top_q[31] ^ opnd_q[31];
		end
		if (cmd.commit) begin
			top_q        <= nxt_top;
			res_value_q  <= res_val;
			res_depth_q  <= depth_ext[DEPTH_FIELD_W-1:0];
			res_status_q <= res_status;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = res_value_q;
	assign rsp.stack_depth  = res_depth_q;
	assign rsp.status       = res_status_q;

endmodule

@@ hdl/rpn_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpn_ctrl
// Controller: sequences decode, operand read, arithmetic and commit of each
// request.
// ----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	rpn_state_t state_q;
	rpn_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.need_read) begin
					cmd.rd_go = 1'b1;
					state_d   = S_READ;
				end else if (stat.use_mul) begin
					state_d = S_OPER;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				cmd.rd_latch = 1'b1;
				state_d      = S_OPER;
			end
			S_OPER: begin
				if (stat.use_mul) begin
					cmd.mul_go = 1'b1;
					state_d    = S_FINISH;
				end else if (stat.use_div && !stat.div_zero) begin
					cmd.div_go = 1'b1;
					state_d    = S_DIV;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// Hold the result until the response register can take it.
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/rpn_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Push, clear, pop of the last entry or an empty stack and refusals for too few
// operands or a full stack go straight to commit; square adds a multiply step; add,
// subtract, multiply, pop and divide by zero read the operand from the RAM first;
// divide also waits for the radix-4 divider. One request runs at a time; a waiting
// response holds back the commit of the next. Reset empties the stack and drops it.
// ----------------------------------------------------------------------------
module rpn_stack_calculator import rpn_pkg::*; #(
	parameter int STACK_DEPTH = RPN_STACK_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	rpn_req_if.sink   req,
	rpn_rsp_if.source rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	assign req.ready = in_ready;

	rpn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rpn_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (req.req_type),
		.push_value(req.push_value),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free)
		else $error("commit while the response register is occupied");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in progress");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("committed word not presented on the response channel");

	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.div_done |-> !req.ready)
		else $error("request accepted while the divider is busy");
`endif

endmodule

@@ dv/rpn_stack_calculator_tb.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_calculator_tb
// Self-checking testbench for the RPN calculator stack engine. A shadow stack
// in the bench predicts the answer word of every accepted request: Q16.16
// arithmetic with saturation, and each flagged case. Answer words are compared
// field by field, in order, with random idles on both channels unless no_idle.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb import rpn_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CALC_DEPTH  = RPN_STACK_DEPTH;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT = 5000;
	localparam int PRINT_CAP   = 100;

	typedef struct {
		logic [31:0] value;
		logic [4:0]  depth;
		rpn_status_t status;
	} calc_answer_t;

	logic clk = 1'b0;
	logic arst_n;

	rpn_req_if req_bus();
	rpn_rsp_if rsp_bus();

	rpn_stack_calculator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Shadow copy of the calculator stack.
	logic [31:0]  calc_stack [CALC_DEPTH];
	int           calc_count;
	calc_answer_t pending_answers [$];

	bit no_idle;
	int cycle_count;
	int error_count;
	int sent_count;
	int checked_count;
	int status_seen [6];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d answers outstanding", cycle_count,
				pending_answers.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		// Every mismatch counts; only the first ones are printed.
		if (error_count < PRINT_CAP)
			$display("ERROR cycle %0d answer %0d: %s got 0x%08h expected 0x%08h",
				cycle_count, checked_count, what, got, want);
		error_count++;
	endtask

	function automatic logic [31:0] clamp_value(input longint v, output bit hit);
		hit = 1'b0;
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic predict_answer(rpn_req_t op, logic [31:0] operand);
		calc_answer_t ans;
		longint t;
		longint s;
		longint r;
		bit hit;
		ans.status = ST_OK;
		ans.value = 32'h0;
		t = 0;
		s = 0;
		r = 0;
		hit = 1'b0;
		if (calc_count >= 1)
			t = $signed(calc_stack[calc_count-1]);
		if (calc_count >= 2)
			s = $signed(calc_stack[calc_count-2]);
		case (op)
			REQ_PUSH: begin
				if (calc_count >= CALC_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					calc_stack[calc_count] = operand;
					calc_count++;
				end
			end
			REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: begin
				if (calc_count < 2) begin
					ans.status = ST_FEW;
				end else if (op == REQ_DIV && s == 0) begin
					ans.status = ST_DIVZ;
				end else begin
					// The top entry is the left operand of subtract and divide.
					case (op)
						REQ_ADD: r = t + s;
						REQ_SUB: r = t - s;
						REQ_MUL: r = (t * s) >>> 16;
						default: r = (t * 64'sd65536) / s;
					endcase
					calc_count--;
					calc_stack[calc_count-1] = clamp_value(r, hit);
					if (hit)
						ans.status = ST_SAT;
				end
			end
			REQ_SQUARE: begin
				if (calc_count < 1) begin
					ans.status = ST_FEW;
				end else begin
					calc_stack[calc_count-1] = clamp_value((t * t) >>> 16, hit);
					if (hit)
						ans.status = ST_SAT;
				end
			end
			REQ_POP: begin
				if (calc_count == 0) begin
					ans.status = ST_EMPTY;
				end else begin
					ans.value = calc_stack[calc_count-1];
					calc_count--;
				end
			end
			default: calc_count = 0;
		endcase
		if (op != REQ_POP)
			ans.value = (calc_count == 0) ? 32'h0 : calc_stack[calc_count-1];
		ans.depth = calc_count[4:0];
		status_seen[ans.status]++;
		pending_answers.push_back(ans);
	endtask

	// Called at a falling edge, returns at a falling edge. Valid is left high
	// so that back-to-back words need no extra assignment.
	task automatic send_word(rpn_req_t op, logic [31:0] operand);
		while (!no_idle && $urandom_range(99) < 9) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.req_type   <= op;
		req_bus.push_value <= operand;
		do
			@(posedge clk);
		while (!req_bus.ready);
		predict_answer(op, operand);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		int waited;
		waited = 0;
		req_bus.valid <= 1'b0;
		@(negedge clk);
		while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
	endtask

	always @(negedge clk) begin
		if (no_idle)
			rsp_bus.ready <= 1'b1;
		else
			rsp_bus.ready <= ($urandom_range(99) >= 9);
	end

	always @(posedge clk) begin : check_answers
		calc_answer_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected word, result_value", rsp_bus.result_value, 32'h0);
			end else begin
				want = pending_answers.pop_front();
				if (rsp_bus.result_value !== want.value)
					report_mismatch("result_value", rsp_bus.result_value, want.value);
				if (rsp_bus.stack_depth !== want.depth)
					report_mismatch("stack_depth", 32'(rsp_bus.stack_depth), 32'(want.depth));
				if (rsp_bus.status !== want.status)
					report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
			end
			checked_count++;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3, 4, 5: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
			6, 7:    return ($urandom_range(64) - 32) << 16;
			8: begin
				case ($urandom_range(4))
					0:       return 32'h0000_0000;
					1:       return 32'h7FFF_FFFF;
					2:       return 32'h8000_0000;
					3:       return 32'h0001_0000;
					default: return 32'hFFFF_0000;
				endcase
			end
			default: return {16'h0, 16'($urandom)};
		endcase
	endfunction

	// Keeps the stack mostly populated so that arithmetic gets past the
	// too-few-operands check.
	function automatic rpn_req_t pick_operation();
		int roll;
		roll = $urandom_range(99);
		if (calc_count < 2 && roll < 70)
			return REQ_PUSH;
		if (roll < 35)
			return REQ_PUSH;
		if (roll < 47)
			return REQ_ADD;
		if (roll < 59)
			return REQ_SUB;
		if (roll < 71)
			return REQ_MUL;
		if (roll < 81)
			return REQ_DIV;
		if (roll < 89)
			return REQ_SQUARE;
		if (roll < 97)
			return REQ_POP;
		return REQ_CLEAR;
	endfunction

	task automatic send_random_expressions(int count);
		rpn_req_t op;
		repeat (count) begin
			op = pick_operation();
			send_word(op, (op == REQ_PUSH) ? pick_value() : $urandom);
		end
	endtask

	task automatic test_directed_cases();
		send_word(REQ_POP, 32'h1234_5678);
		send_word(REQ_ADD, 32'h0);
		send_word(REQ_SQUARE, 32'h0);
		send_word(REQ_PUSH, 32'h7FFF_FFFF);
		send_word(REQ_SUB, 32'hFFFF_FFFF);
		send_word(REQ_SQUARE, 32'h0);
		send_word(REQ_PUSH, 32'h8000_0000);
		send_word(REQ_ADD, 32'h0);
		// A zero divisor below the top leaves the stack untouched.
		send_word(REQ_PUSH, 32'h0000_0000);
		send_word(REQ_PUSH, 32'h0005_0000);
		send_word(REQ_DIV, 32'h0);
		send_word(REQ_SUB, 32'h0);
		send_word(REQ_DIV, 32'h0);
		send_word(REQ_PUSH, 32'hFFFF_0000);
		send_word(REQ_PUSH, 32'h8000_0000);
		send_word(REQ_DIV, 32'h0);
		send_word(REQ_PUSH, 32'h0003_0000);
		send_word(REQ_MUL, 32'h0);
		// A negative product rounds toward minus infinity.
		send_word(REQ_PUSH, 32'hFFFF_FFFF);
		send_word(REQ_PUSH, 32'h0000_8000);
		send_word(REQ_MUL, 32'h0);
		send_word(REQ_POP, 32'h0);
		send_word(REQ_CLEAR, 32'hFFFF_FFFF);
		send_word(REQ_PUSH, 32'h5555_AAAA);
		send_word(REQ_POP, 32'h0);
	endtask

	task automatic test_random_expressions();
		send_random_expressions(300);
	endtask

	task automatic test_paused_bursts();
		repeat (5) begin
			send_random_expressions(10);
			wait_for_drain();
		end
	endtask

	task automatic test_steady_stream();
		no_idle = 1'b1;
		send_random_expressions(150);
		no_idle = 1'b0;
	endtask

	task automatic test_full_stack_runs();
		repeat (4) begin
			while (calc_count < CALC_DEPTH)
				send_word(REQ_PUSH, pick_value());
			repeat ($urandom_range(3, 1))
				send_word(REQ_PUSH, pick_value());
			send_random_expressions(5);
		end
	endtask

	task automatic test_random_noise();
		repeat (150)
			send_word(rpn_req_t'($urandom_range(7)), $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		calc_count = 0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_PUSH;
		req_bus.push_value = 32'h0;
		rsp_bus.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_expressions();
		test_paused_bursts();
		test_steady_stream();
		test_full_stack_runs();
		test_random_noise();

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_answers.size() != 0)
			report_mismatch("answers never returned, count", pending_answers.size(), 32'h0);

		$display("Sent %0d requests and checked %0d answer words in %0d cycles.",
			sent_count, checked_count, cycle_count);
		$display("Status mix: ok %0d, few %0d, divz %0d, full %0d, empty %0d, sat %0d.",
			status_seen[ST_OK], status_seen[ST_FEW], status_seen[ST_DIVZ],
			status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_SAT]);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/rpn_pkg.sv
hdl/rpn_req_if.sv
hdl/rpn_rsp_if.sv
hdl/rpn_ram.sv
hdl/rpn_div.sv
hdl/rpn_dp.sv
hdl/rpn_ctrl.sv
hdl/rpn_stack_calculator.sv
dv/rpn_stack_calculator_tb.sv
